FILE: design/refcounted_palette_table_assert.svh
// Assertion macros shared by the palette table RTL.
// Expects i_clk and i_rst_n in the scope of use.
`ifndef REFCOUNTED_PALETTE_TABLE_ASSERT_SVH
`define REFCOUNTED_PALETTE_TABLE_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define RPT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define RPT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/rpt_pkg.sv
// Shared types and constants for the refcounted palette table.
// No dependencies.
package rpt_pkg;

    localparam int ENTRIES    = 16;
    localparam int COUNT_BITS = 16;
    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int COLOR_W    = 32;
    localparam int SLOT_W     = 4;
    localparam int SEL_W      = 4;
    localparam int OP_W       = 3;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Operation codes; other encodings are no-ops
    typedef enum logic [OP_W-1:0] {
        OP_ADD         = 3'd0,
        OP_REMOVE      = 3'd1,
        OP_LOOKUP      = 3'd2,
        OP_READ        = 3'd3,
        OP_CLR_CHANGED = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_EMIT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic scan;
        logic update;
        logic emit;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            scan_hit;
        logic            scan_last;
        logic            out_busy;
    } t_dp_status;

endpackage

FILE: design/refcounted_palette_table.sv
// Refcounted palette table: 16 colors with saturating use counts, scanned one entry a cycle.
// Add/remove: accept, a scan of up to 16 entries, update, then the result.
// Lookup skips the update step; read and read-and-clear go straight from accept to the result.
// One request is in flight at a time; the scan and any stall on the result set the rate.
// Synchronous active-low reset clears colors, counts, changed flag and the FSM.
// Depends on rpt_pkg, rpt_ctrl and rpt_dp.
module refcounted_palette_table
    import rpt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [OP_W-1:0]    i_operation,
    input  logic [COLOR_W-1:0] i_color_value,
    input  logic [SEL_W-1:0]   i_slot_select,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [SLOT_W-1:0]  o_slot_index,
    output logic               o_hit,
    output logic [COLOR_W-1:0] o_slot_color,
    output logic               o_palette_changed
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    rpt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_operation),
        .i_status   (w_status),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    rpt_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_op              (i_operation),
        .i_color           (i_color_value),
        .i_sel             (i_slot_select),
        .i_out_stall       (i_out_stall),
        .o_status          (w_status),
        .o_out_valid       (o_out_valid),
        .o_slot_index      (o_slot_index),
        .o_hit             (o_hit),
        .o_slot_color      (o_slot_color),
        .o_palette_changed (o_palette_changed)
    );

endmodule

FILE: design/rpt_ctrl.sv
// Controller FSM for the refcounted palette table.
// Depends on rpt_pkg.
module rpt_ctrl
    import rpt_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic [OP_W-1:0] i_op,
    input  t_dp_status      i_status,
    output logic            o_in_stall,
    output t_dp_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   w_accept;
    logic   w_needs_scan;

    assign w_accept     = i_in_valid && (r_state == ST_IDLE);
    assign w_needs_scan = (i_op == OP_ADD) || (i_op == OP_REMOVE) || (i_op == OP_LOOKUP);

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = w_needs_scan ? ST_SCAN : ST_EMIT;
                end
            end
            ST_SCAN: begin
                if (i_status.scan_hit || i_status.scan_last) begin
                    n_state = (i_status.op == OP_LOOKUP) ? ST_EMIT : ST_UPDATE;
                end
            end
            ST_UPDATE: n_state = ST_EMIT;
            ST_EMIT: begin
                if (!i_status.out_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd      = '0;
        o_in_stall = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE:   o_cmd.load   = w_accept;
            ST_SCAN:   o_cmd.scan   = 1'b1;
            ST_UPDATE: o_cmd.update = 1'b1;
            ST_EMIT:   o_cmd.emit   = !i_status.out_busy;
            default:   o_cmd        = '0;
        endcase
    end

endmodule

FILE: design/rpt_dp.sv
// Datapath for the refcounted palette table: store, scan, update, result register.
// Depends on rpt_pkg and refcounted_palette_table_assert.svh.
`include "refcounted_palette_table_assert.svh"

module rpt_dp
    import rpt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    input  logic [OP_W-1:0]    i_op,
    input  logic [COLOR_W-1:0] i_color,
    input  logic [SEL_W-1:0]   i_sel,
    input  logic               i_out_stall,
    output t_dp_status         o_status,
    output logic               o_out_valid,
    output logic [SLOT_W-1:0]  o_slot_index,
    output logic               o_hit,
    output logic [COLOR_W-1:0] o_slot_color,
    output logic               o_palette_changed
);

    logic [COLOR_W-1:0]    r_colors [ENTRIES];
    logic [COUNT_BITS-1:0] r_counts [ENTRIES];
    logic                  r_changed;

    // Latched request
    logic [OP_W-1:0]    r_op;
    logic [COLOR_W-1:0] r_color;
    logic [SEL_W-1:0]   r_sel;

    // Scan state
    logic [IDX_W-1:0] r_idx;
    logic             r_found;
    logic [IDX_W-1:0] r_mslot;
    logic             r_free_found;
    logic [IDX_W-1:0] r_fslot;

    // Result register
    logic               r_o_valid;
    logic [SLOT_W-1:0]  r_o_slot;
    logic               r_o_hit;
    logic [COLOR_W-1:0] r_o_color;
    logic               r_o_chg;
    logic [SLOT_W-1:0]  n_o_slot;
    logic               n_o_hit;
    logic [COLOR_W-1:0] n_o_color;
    logic               n_o_chg;

    logic             w_match;
    logic             w_free;
    logic             w_out_busy;
    logic [IDX_W-1:0] w_tslot;

    assign w_match    = (r_colors[r_idx] == r_color);
    assign w_free     = (r_counts[r_idx] == '0);
    assign w_out_busy = r_o_valid && i_out_stall;
    assign w_tslot    = r_found ? r_mslot : r_fslot;

    assign o_status.op        = r_op;
    assign o_status.scan_hit  = w_match;
    assign o_status.scan_last = (32'(r_idx) == ENTRIES - 1);
    assign o_status.out_busy  = w_out_busy;

    // Request latch and scan bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
            r_idx        <= '0;
        end else if (i_cmd.load) begin
            r_op         <= i_op;
            r_color      <= i_color;
            r_sel        <= i_sel;
            r_idx        <= '0;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
        end else if (i_cmd.scan) begin
            if (w_match) begin
                r_found <= 1'b1;
                r_mslot <= r_idx;
            end
            if (w_free && !r_free_found) begin
                r_free_found <= 1'b1;
                r_fslot      <= r_idx;
            end
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    // Store and changed flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                r_colors[i] <= '0;
                r_counts[i] <= '0;
            end
            r_changed <= 1'b0;
        end else if (i_cmd.update) begin
            if (r_found) begin
                if (r_op == OP_ADD) begin
                    if (r_counts[r_mslot] == '0) begin
                        r_changed <= 1'b1;
                    end
                    if (r_counts[r_mslot] != COUNT_MAX) begin
                        r_counts[r_mslot] <= r_counts[r_mslot] + COUNT_BITS'(1);
                    end
                end else if (r_counts[r_mslot] != '0) begin
                    r_counts[r_mslot] <= r_counts[r_mslot] - COUNT_BITS'(1);
                end
            end else if ((r_op == OP_ADD) && r_free_found) begin
                // Claim the first free entry
                r_colors[r_fslot] <= r_color;
                r_counts[r_fslot] <= COUNT_BITS'(1);
                r_changed         <= 1'b1;
            end
        end else if (i_cmd.emit && (r_op == OP_CLR_CHANGED)) begin
            r_changed <= 1'b0;
        end
    end

    // Result fields
    always_comb begin
        n_o_slot  = '0;
        n_o_hit   = 1'b0;
        n_o_color = '0;
        n_o_chg   = 1'b0;
        case (r_op)
            OP_ADD: begin
                n_o_hit  = r_found || r_free_found;
                n_o_slot = n_o_hit ? SLOT_W'(w_tslot) : '0;
            end
            OP_REMOVE, OP_LOOKUP: begin
                n_o_hit  = r_found;
                n_o_slot = r_found ? SLOT_W'(r_mslot) : '0;
            end
            OP_READ: begin
                if (32'(r_sel) < ENTRIES) begin
                    n_o_color = r_colors[IDX_W'(r_sel)];
                end
            end
            OP_CLR_CHANGED: n_o_chg = r_changed;
            default: n_o_hit = 1'b0;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_o_valid <= 1'b1;
            r_o_slot  <= n_o_slot;
            r_o_hit   <= n_o_hit;
            r_o_color <= n_o_color;
            r_o_chg   <= n_o_chg;
        end else if (r_o_valid && !i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    assign o_out_valid       = r_o_valid;
    assign o_slot_index      = r_o_slot;
    assign o_hit             = r_o_hit;
    assign o_slot_color      = r_o_color;
    assign o_palette_changed = r_o_chg;

    `RPT_ASSERT_NOW(a_emit_when_free, i_cmd.emit, !w_out_busy, "result loaded over a stalled one")
    `RPT_ASSERT_NEXT(a_emit_valid, i_cmd.emit, r_o_valid, "emitted result not valid")
    `RPT_ASSERT_NEXT(a_add_count, i_cmd.update && (r_op == OP_ADD) && (r_found || r_free_found),
        r_counts[$past(w_tslot)] != '0, "added entry left with zero count")
    `RPT_ASSERT_NEXT(a_chg_clear, i_cmd.emit && (r_op == OP_CLR_CHANGED), !r_changed,
        "changed flag not cleared")

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the refcounted palette table: directed rows, random traffic,
// a back-to-back burst and a random tail, scored against typed answers or an in-bench model.
// Depends on rpt_pkg and the refcounted_palette_table RTL.
module tb_top;
    import rpt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RESET_CYCLES = 10;
    localparam int          RANDOM_ITEMS = 870;
    localparam int          BURST_ADDS   = 8;
    localparam int          TAIL_ITEMS   = 40;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          POOL_SIZE    = 20;
    localparam int          MAX_REPORTS  = 100;
    localparam int unsigned CYCLE_LIMIT  = 4_000_000;

    // Encodings outside t_op; the block must treat them as no-ops
    localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_MID   = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot_index;
        logic               hit;
        logic [COLOR_W-1:0] slot_color;
        logic               changed;
    } t_palette_result;

    // One directed request; the w_ fields hold a typed-in answer when typed is set
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [COLOR_W-1:0] color;
        logic [SEL_W-1:0]   sel;
        logic               typed;
        logic [SLOT_W-1:0]  w_slot;
        logic               w_hit;
        logic [COLOR_W-1:0] w_color;
        logic               w_chg;
    } t_directed_row;

    localparam int NUM_DIRECTED = 26;
    localparam t_directed_row DIRECTED_ROWS [NUM_DIRECTED] = '{
        // fresh table: every entry holds color 0 with count 0
        '{OP_READ,        32'h0000_0000, 4'd0,  1'b1, 4'd0, 1'b0, 32'h0000_0000, 1'b0},
        '{OP_READ,        32'hFFFF_FFFF, 4'd15, 1'b1, 4'd0, 1'b0, 32'h0000_0000, 1'b0},
        '{OP_CLR_CHANGED, 32'h0000_0000, 4'd0,  1'b1, 4'd0, 1'b0, 32'h0000_0000, 1'b0},
        '{OP_LOOKUP,      32'h0000_0000, 4'd0,  1'b1, 4'd0, 1'b1, 32'h0000_0000, 1'b0},
        '{OP_LOOKUP,      32'hFFFF_FFFF, 4'd0,  1'b1, 4'd0, 1'b0, 32'h0000_0000, 1'b0},
        // remove at count zero still hits; remove of an absent color misses
        '{OP_REMOVE,      32'h0000_0000, 4'd0,  1'b1, 4'd0, 1'b1, 32'h0000_0000, 1'b0},
        '{OP_REMOVE,      32'hFFFF_FFFF, 4'd0,  1'b1, 4'd0, 1'b0, 32'h0000_0000, 1'b0},
        // add of color 0 revives the stale entry 0 and marks the palette changed
        '{OP_ADD,         32'h0000_0000, 4'd0,  1'b1, 4'd0, 1'b1, 32'h0000_0000, 1'b0},
        '{OP_CLR_CHANGED, 32'h0000_0000, 4'd0,  1'b1, 4'd0, 1'b0, 32'h0000_0000, 1'b1},
        '{OP_CLR_CHANGED, 32'hFFFF_FFFF, 4'd15, 1'b1, 4'd0, 1'b0, 32'h0000_0000, 1'b0},
        // new color claims the first free entry
        '{OP_ADD,         32'hFFFF_FFFF, 4'd0,  1'b1, 4'd1, 1'b1, 32'h0000_0000, 1'b0},
        '{OP_READ,        32'h0000_0000, 4'd1,  1'b1, 4'd0, 1'b0, 32'hFFFF_FFFF, 1'b0},
        '{OP_LOOKUP,      32'h0000_0000, 4'd0,  1'b1, 4'd0, 1'b1, 32'h0000_0000, 1'b0},
        '{OP_ADD,         32'h0000_0000, 4'd0,  1'b0, 4'd0, 1'b0, 32'h0000_0000, 1'b0},
        '{OP_REMOVE,      32'h0000_0000, 4'd0,  1'b0, 4'd0, 1'b0, 32'h0000_0000, 1'b0},
        '{OP_REMOVE,      32'h0000_0000, 4'd0,  1'b0, 4'd0, 1'b0, 32'h0000_0000, 1'b0},
        '{OP_CLR_CHANGED, 32'h0000_0000, 4'd0,  1'b0, 4'd0, 1'b0, 32'h0000_0000, 1'b0},
        '{OP_ADD,         32'h0000_0000, 4'd0,  1'b0, 4'd0, 1'b0, 32'h0000_0000, 1'b0},
        // spare encodings return all zeros
        '{OP_SPARE_FIRST, 32'hFFFF_FFFF, 4'd15, 1'b1, 4'd0, 1'b0, 32'h0000_0000, 1'b0},
        '{OP_SPARE_MID,   32'h0000_0000, 4'd1,  1'b1, 4'd0, 1'b0, 32'h0000_0000, 1'b0},
        '{OP_SPARE_LAST,  32'hFFFF_FFFF, 4'd0,  1'b1, 4'd0, 1'b0, 32'h0000_0000, 1'b0},
        // stale entry with a nonzero color still matches
        '{OP_ADD,         32'h1234_5678, 4'd0,  1'b0, 4'd0, 1'b0, 32'h0000_0000, 1'b0},
        '{OP_READ,        32'h0000_0000, 4'd2,  1'b0, 4'd0, 1'b0, 32'h0000_0000, 1'b0},
        '{OP_REMOVE,      32'h1234_5678, 4'd0,  1'b0, 4'd0, 1'b0, 32'h0000_0000, 1'b0},
        '{OP_LOOKUP,      32'h1234_5678, 4'd0,  1'b0, 4'd0, 1'b0, 32'h0000_0000, 1'b0},
        '{OP_ADD,         32'h1234_5678, 4'd0,  1'b0, 4'd0, 1'b0, 32'h0000_0000, 1'b0}
    };

    logic               i_clk             = 1'b0;
    logic               i_rst_n           = 1'b0;
    logic               i_in_valid        = 1'b0;
    logic               o_in_stall;
    logic [OP_W-1:0]    i_operation       = '0;
    logic [COLOR_W-1:0] i_color_value     = '0;
    logic [SEL_W-1:0]   i_slot_select     = '0;
    logic               o_out_valid;
    logic               i_out_stall       = 1'b0;
    logic [SLOT_W-1:0]  o_slot_index;
    logic               o_hit;
    logic [COLOR_W-1:0] o_slot_color;
    logic               o_palette_changed;

    // Palette model state, cleared like the block at reset
    logic [COLOR_W-1:0]    palette_colors [ENTRIES] = '{default: '0};
    logic [COUNT_BITS-1:0] palette_counts [ENTRIES] = '{default: '0};
    logic                  palette_dirty            = 1'b0;

    t_palette_result    expected_results [$];
    logic [COLOR_W-1:0] color_pool [POOL_SIZE];
    int unsigned        mismatch_count = 0;
    int unsigned        cycle_count    = 0;
    int                 burst_left     = 0;
    bit                 quiet          = 1'b0;
    bit                 filling        = 1'b1;

    // Receiver stall pattern
    int unsigned        stall_mode     = 0;
    int unsigned        stall_left     = 0;
    int unsigned        stall_phase    = 0;
    int unsigned        stall_period   = 1;
    int unsigned        stall_duty     = 0;

    refcounted_palette_table dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_operation       (i_operation),
        .i_color_value     (i_color_value),
        .i_slot_select     (i_slot_select),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_slot_index      (o_slot_index),
        .o_hit             (o_hit),
        .o_slot_color      (o_slot_color),
        .o_palette_changed (o_palette_changed)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [COLOR_W-1:0] want,
                                   input logic [COLOR_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("MISMATCH @%0t %s: expected %h, got %h", $realtime, what, want, got);
    endtask

    // Applies one request to the palette model and returns the result it should produce
    function automatic t_palette_result palette_step(input logic [OP_W-1:0] op,
                                                     input logic [COLOR_W-1:0] color,
                                                     input logic [SEL_W-1:0] sel);
        t_palette_result r;
        int              m;
        r = '0;
        m = -1;
        for (int i = ENTRIES - 1; i >= 0; i--)
            if (palette_colors[i] == color) m = i;
        case (op)
            OP_ADD: begin
                if (m < 0) begin
                    for (int i = ENTRIES - 1; i >= 0; i--)
                        if (palette_counts[i] == '0) m = i;
                    if (m >= 0) begin
                        palette_colors[m] = color;
                        palette_counts[m] = COUNT_BITS'(1);
                        palette_dirty     = 1'b1;
                    end
                end else begin
                    if (palette_counts[m] == '0) palette_dirty = 1'b1;
                    if (palette_counts[m] != COUNT_MAX)
                        palette_counts[m] = palette_counts[m] + COUNT_BITS'(1);
                end
            end
            OP_REMOVE: begin
                if (m >= 0 && palette_counts[m] != '0)
                    palette_counts[m] = palette_counts[m] - COUNT_BITS'(1);
            end
            OP_READ: begin
                if (int'(sel) < ENTRIES) r.slot_color = palette_colors[sel];
            end
            OP_CLR_CHANGED: begin
                r.changed     = palette_dirty;
                palette_dirty = 1'b0;
            end
            default: ;
        endcase
        if ((op == OP_ADD || op == OP_REMOVE || op == OP_LOOKUP) && m >= 0) begin
            r.slot_index = m[SLOT_W-1:0];
            r.hit        = 1'b1;
        end
        return r;
    endfunction

    // Sends one request, in bursts with random gaps unless quiet is set; queues its expected result on acceptance
    task automatic issue_request(input logic [OP_W-1:0] op, input logic [COLOR_W-1:0] color,
                                 input logic [SEL_W-1:0] sel, input bit typed,
                                 input t_palette_result typed_result);
        t_palette_result predicted;
        if (!quiet && burst_left <= 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                      : $urandom_range(1, 24);
        end
        burst_left--;
        i_in_valid    <= 1'b1;
        i_operation   <= op;
        i_color_value <= color;
        i_slot_select <= sel;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        predicted = palette_step(op, color, sel);
        expected_results.push_back(typed ? typed_result : predicted);
    endtask

    // Random requests; colors mostly from a small pool so entries match, fill up and drain
    task automatic random_traffic(input int count);
        logic [OP_W-1:0]    op;
        logic [COLOR_W-1:0] color;
        int unsigned        roll;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) == 0) filling = !filling;
            roll = $urandom_range(0, 99);
            if (roll < (filling ? 50 : 20))       op = OP_ADD;
            else if (roll < (filling ? 62 : 65))  op = OP_REMOVE;
            else if (roll < (filling ? 75 : 78))  op = OP_LOOKUP;
            else if (roll < (filling ? 87 : 88))  op = OP_READ;
            else if (roll < 96)                   op = OP_CLR_CHANGED;
            else op = OP_W'(OP_SPARE_FIRST + $urandom_range(0, OP_SPARE_LAST - OP_SPARE_FIRST));
            color = ($urandom_range(0, 9) == 0) ? $urandom()
                                                 : color_pool[$urandom_range(0, POOL_SIZE - 1)];
            issue_request(op, color, SEL_W'($urandom_range(0, ENTRIES - 1)), 1'b0, '0);
        end
    endtask

    // Result checking and receiver stall pattern
    always @(posedge i_clk) begin
        t_palette_result want;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result, slot_color", '0, o_slot_color);
            end else begin
                want = expected_results.pop_front();
                if (o_slot_index !== want.slot_index)
                    report_mismatch("slot_index", COLOR_W'(want.slot_index),
                                    COLOR_W'(o_slot_index));
                if (o_hit !== want.hit)
                    report_mismatch("hit", COLOR_W'(want.hit), COLOR_W'(o_hit));
                if (o_slot_color !== want.slot_color)
                    report_mismatch("slot_color", want.slot_color, o_slot_color);
                if (o_palette_changed !== want.changed)
                    report_mismatch("palette_changed", COLOR_W'(want.changed),
                                    COLOR_W'(o_palette_changed));
            end
        end
        if (stall_left == 0) begin
            stall_mode   = $urandom_range(0, 2);
            stall_left   = $urandom_range(64, 256);
            stall_period = $urandom_range(2, 12);
            stall_duty   = $urandom_range(1, stall_period - 1);
        end
        stall_left--;
        stall_phase++;
        if (quiet || !i_rst_n)
            i_out_stall <= 1'b0;
        else if (stall_mode == 1)
            i_out_stall <= $urandom_range(0, 1);
        else if (stall_mode == 2)
            i_out_stall <= (stall_phase % stall_period) < stall_duty;
        else
            i_out_stall <= 1'b0;
    end

    // Stimulus
    initial begin
        t_palette_result typed_result;
        logic [COLOR_W-1:0] hot_color;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows
        for (int r = 0; r < NUM_DIRECTED; r++) begin
            typed_result = '{DIRECTED_ROWS[r].w_slot, DIRECTED_ROWS[r].w_hit,
                             DIRECTED_ROWS[r].w_color, DIRECTED_ROWS[r].w_chg};
            issue_request(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].color, DIRECTED_ROWS[r].sel,
                          DIRECTED_ROWS[r].typed, typed_result);
        end

        // random traffic; pool keeps both all-zero and all-one colors
        color_pool[0] = '0;
        color_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) color_pool[i] = $urandom();
        random_traffic(RANDOM_ITEMS);

        // back-to-back adds on entry 0's color, with no gaps and no result stalls
        quiet     = 1'b1;
        hot_color = palette_colors[0];
        repeat (BURST_ADDS) issue_request(OP_ADD, hot_color, '0, 1'b0, '0);
        issue_request(OP_CLR_CHANGED, '0, '0, 1'b0, '0);
        issue_request(OP_ADD, hot_color, '0, 1'b0, '0);
        issue_request(OP_CLR_CHANGED, '0, '0, 1'b0, '0);
        issue_request(OP_REMOVE, hot_color, '0, 1'b0, '0);
        quiet = 1'b0;

        // a little more traffic after the burst
        random_traffic(TAIL_ITEMS);
        i_in_valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
